// File: hdl/circular_curve_point_offsets_assert.svh
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef CIRCULAR_CURVE_POINT_OFFSETS_ASSERT_SVH
`define CIRCULAR_CURVE_POINT_OFFSETS_ASSERT_SVH

// condition implies consequence in the same cycle
`define CCPO_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define CCPO_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ccpo_pkg.sv
`default_nettype none

package ccpo_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int MAX_POINTS_DEF    = 1023;

	localparam int IDX_W  = 11;
	localparam int LEN_W  = 20;
	localparam int NPT_W  = 10;
	localparam int OFS_W  = 21;
	localparam int ST_W   = 2;
	localparam int SIN_W  = 31;
	localparam int Z_W    = 33;
	localparam int XY_W   = 34;

	// register indexes
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_ARC    = 2'd1;
	localparam logic [1:0] REG_POINTS = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_INDEX  = 2'd1;
	localparam logic [ST_W-1:0] ST_RADIUS = 2'd2;
	localparam logic [ST_W-1:0] ST_ANGLE  = 2'd3;

	localparam logic [LEN_W-1:0] RADIUS_RST = 20'd100000;
	localparam logic [LEN_W-1:0] ARC_RST    = 20'd50000;
	localparam logic [NPT_W-1:0] POINTS_RST = 10'd4;

	// pi in Q3.29, cordic gain in Q2.30, one in Q2.30
	localparam logic [31:0] PI_Q29   = 32'd1686629713;
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

	localparam logic [31:0] ATAN_LOW [10] = '{
		32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
		32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575
	};

	// atan(2^-i) in Q3.29
	function automatic logic [31:0] cordic_atan(input int i);
		logic [31:0] v;
		if (i < 10) begin
			v = ATAN_LOW[i[3:0]];
		end else if (i >= 30) begin
			v = 32'd0;
		end else begin
			v = 32'(32'd1 << (29 - i));
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hdl/ccpo_cordic.sv
`default_nettype none

module ccpo_cordic #(
	parameter int STAGES = ccpo_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [ccpo_pkg::Z_W-1:0]       z_in,
	output logic         [ccpo_pkg::SIN_W-1:0]         sine
);
	import ccpo_pkg::*;

	logic signed [XY_W-1:0] x_s [0:STAGES];
	logic signed [XY_W-1:0] y_s [0:STAGES];
	logic signed [Z_W-1:0]  z_s [0:STAGES];

	assign x_s[0] = $signed(XY_W'(GAIN_Q30));
	assign y_s[0] = '0;
	assign z_s[0] = z_in;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [Z_W-1:0] ATAN_I = $signed({1'b0, cordic_atan(i)});
		logic signed [XY_W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end
			end
		end
	end

	// clamp to [0, 1] in Q2.30
	always_comb begin
		if (y_s[STAGES][XY_W-1]) begin
			sine = '0;
		end else if (y_s[STAGES] > $signed({3'b000, ONE_Q30})) begin
			sine = ONE_Q30;
		end else begin
			sine = SIN_W'(y_s[STAGES]);
		end
	end

endmodule

`default_nettype wire

// File: hdl/circular_curve_point_offsets.sv
// circular curve stake-out by tangent offsets
//
// input channel: in_valid / in_ready carry point_index k. output channel:
// out_valid / out_ready carry x_offset_mm, y_offset_mm, arc_distance_mm and
// status, one result per input in input order.
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 radius, 1 total arc, 2 intermediate points); write only while idle.
// path: an input passes the index checks, the rounded dividends, the 32
// quotient stages of the angle divider, the angle stage, the cordic stages,
// the multiply stages and the output register on its way to out_valid.
// throughput: one item per cycle while not stalled, every stage is a register slice.
// stall: when out_valid is high and out_ready low the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
// reset: valid bits clear, registers return to radius 100000 mm, arc
// 50000 mm and 4 intermediate points. no clearing pass is needed.
`default_nettype none
`include "circular_curve_point_offsets_assert.svh"

module circular_curve_point_offsets #(
	parameter int CORDIC_STAGES = ccpo_pkg::CORDIC_STAGES_DEF,
	parameter int MAX_POINTS    = ccpo_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic        [ccpo_pkg::IDX_W-1:0]    point_index,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed      [ccpo_pkg::OFS_W-1:0]    x_offset_mm,
	output logic             [ccpo_pkg::OFS_W-1:0]    y_offset_mm,
	output logic             [ccpo_pkg::LEN_W-1:0]    arc_distance_mm,
	output logic             [ccpo_pkg::ST_W-1:0]     status,
	input  wire logic                                 cfg_wr_en,
	input  wire logic        [1:0]                    cfg_index,
	input  wire logic        [ccpo_pkg::LEN_W-1:0]    cfg_data
);
	import ccpo_pkg::*;

	localparam int DIV_STEPS = 32;

	// sideband through the divider stages
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             ovf;
		logic [LEN_W-1:0] radius;
		logic [30:0]      den;
		logic [10:0]      segs;
	} div_sb_t;

	// sideband through the cordic and multiply stages
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [LEN_W-1:0] radius;
		logic [LEN_W-1:0] arc;
	} pt_sb_t;

	// configuration registers
	logic [LEN_W-1:0] radius_q, arc_len_q;
	logic [NPT_W-1:0] points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			arc_len_q <= ARC_RST;
			points_q  <= POINTS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q  <= cfg_data;
				REG_ARC:    arc_len_q <= cfg_data;
				REG_POINTS: points_q  <= cfg_data[NPT_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: everything moves when the output register can take a result
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: index checks and the two products
	logic [NPT_W-1:0] n_eff;
	logic [10:0]      segs;
	logic [ST_W-1:0]  err_in;

	assign n_eff = (32'(points_q) > MAX_POINTS) ? NPT_W'(MAX_POINTS) : points_q;
	assign segs  = {1'b0, n_eff} + 11'd1;

	always_comb begin
		if (point_index > segs) begin
			err_in = ST_INDEX;
		end else if (radius_q == '0) begin
			err_in = ST_RADIUS;
		end else begin
			err_in = ST_OK;
		end
	end

	logic             v_s1;
	logic [30:0]      kl_s1, den_s1;
	logic [10:0]      segs_s1;
	logic [ST_W-1:0]  err_s1;
	logic [LEN_W-1:0] radius_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kl_s1     <= 31'(point_index) * 31'(arc_len_q);
			den_s1    <= 31'(segs) * 31'(radius_q);
			segs_s1   <= segs;
			err_s1    <= err_in;
			radius_s1 <= radius_q;
		end
	end

	// stage 2: rounded dividends, overflow of the 32 bit angle quotient
	logic [63:0] d_ang;
	logic [31:0] d_arc;
	assign d_ang = {4'b0000, kl_s1, 29'b0} + 64'(den_s1 >> 1);
	assign d_arc = 32'(kl_s1) + 32'(segs_s1 >> 1);

	// divider stages: index 0 is stage 2, each step retires one quotient bit
	logic        dv_v [0:DIV_STEPS];
	logic [31:0] ra_s [0:DIV_STEPS];
	logic [31:0] qa_s [0:DIV_STEPS];
	logic [10:0] rc_s [0:DIV_STEPS];
	logic [31:0] qc_s [0:DIV_STEPS];
	div_sb_t     dsb_s [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s[0]         <= d_ang[63:32];
			qa_s[0]         <= d_ang[31:0];
			rc_s[0]         <= '0;
			qc_s[0]         <= d_arc;
			dsb_s[0].status <= err_s1;
			dsb_s[0].ovf    <= d_ang[63:32] >= {1'b0, den_s1};
			dsb_s[0].radius <= radius_s1;
			dsb_s[0].den    <= den_s1;
			dsb_s[0].segs   <= segs_s1;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [32:0] ta;
		logic [11:0] tc;
		logic        a_ge, c_ge;
		assign ta   = {ra_s[j], qa_s[j][31]};
		assign tc   = {rc_s[j], qc_s[j][31]};
		assign a_ge = ta >= {2'b00, dsb_s[j].den};
		assign c_ge = tc >= {1'b0, dsb_s[j].segs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ra_s[j+1]  <= a_ge ? 32'(ta - {2'b00, dsb_s[j].den}) : ta[31:0];
				qa_s[j+1]  <= {qa_s[j][30:0], a_ge};
				rc_s[j+1]  <= c_ge ? 11'(tc - {1'b0, dsb_s[j].segs}) : tc[10:0];
				qc_s[j+1]  <= {qc_s[j][30:0], c_ge};
				dsb_s[j+1] <= dsb_s[j];
			end
		end
	end

	// stage 3: angle range check, fold about pi/2 for the sine, half angle
	logic [31:0]     ang, pi_less;
	logic [ST_W-1:0] st_div;
	div_sb_t         dsb_end;

	assign dsb_end = dsb_s[DIV_STEPS];
	assign ang     = qa_s[DIV_STEPS];
	assign pi_less = PI_Q29 - ang;

	always_comb begin
		if (dsb_end.status != ST_OK) begin
			st_div = dsb_end.status;
		end else if (dsb_end.ovf || (ang > PI_Q29)) begin
			st_div = ST_ANGLE;
		end else begin
			st_div = ST_OK;
		end
	end

	logic               v_s3;
	logic signed [Z_W-1:0] zf_s3, zh_s3;
	pt_sb_t             sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zf_s3        <= $signed({1'b0, (ang > pi_less) ? pi_less : ang});
			zh_s3        <= $signed({2'b00, ang[31:1]});
			sb_s3.status <= st_div;
			sb_s3.radius <= dsb_end.radius;
			sb_s3.arc    <= qc_s[DIV_STEPS][LEN_W-1:0];
		end
	end

	// two cordic pipelines: sin(folded angle) and sin(half angle)
	logic [SIN_W-1:0] sin_a, sin_h;

	ccpo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
		.clk  (clk),
		.en   (adv),
		.z_in (zf_s3),
		.sine (sin_a)
	);

	ccpo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_h (
		.clk  (clk),
		.en   (adv),
		.z_in (zh_s3),
		.sine (sin_h)
	);

	// sideband delay matching the cordic depth
	logic   cd_v  [0:CORDIC_STAGES];
	pt_sb_t cd_sb [0:CORDIC_STAGES];

	assign cd_v[0]  = v_s3;
	assign cd_sb[0] = sb_s3;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v[i+1] <= 1'b0;
			end else if (adv) begin
				cd_v[i+1] <= cd_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cd_sb[i+1] <= cd_sb[i];
			end
		end
	end

	// multiply stage 1: R*sin(a) and h*h
	logic        v_m1;
	logic [50:0] xp_m1;
	logic [61:0] hh_m1;
	pt_sb_t      sb_m1;

	// multiply stage 2: round both products
	logic               v_m2;
	logic signed [OFS_W-1:0] x_m2;
	logic [SIN_W-1:0]   sq_m2;
	pt_sb_t             sb_m2;

	// multiply stage 3: R*sq
	logic               v_m3;
	logic signed [OFS_W-1:0] x_m3;
	logic [50:0]        ry_m3;
	pt_sb_t             sb_m3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (adv) begin
			v_m1 <= cd_v[CORDIC_STAGES];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_m1 <= 51'(cd_sb[CORDIC_STAGES].radius) * 51'(sin_a);
			hh_m1 <= 62'(sin_h) * 62'(sin_h);
			sb_m1 <= cd_sb[CORDIC_STAGES];

			x_m2  <= $signed(OFS_W'((52'(xp_m1) + 52'(ONE_Q30 >> 1)) >> 30));
			sq_m2 <= SIN_W'((63'(hh_m1) + 63'(ONE_Q30 >> 1)) >> 30);
			sb_m2 <= sb_m1;

			x_m3  <= x_m2;
			ry_m3 <= 51'(sb_m2.radius) * 51'(sq_m2);
			sb_m3 <= sb_m2;
		end
	end

	// output register, error results carry zero fields
	logic [OFS_W-1:0]        y_round;
	logic signed [OFS_W-1:0] x_q;
	logic [OFS_W-1:0]        y_q;
	logic [LEN_W-1:0]        arc_q;
	logic [ST_W-1:0]         status_q;
	logic                    ok_m3;

	assign y_round = OFS_W'(({ry_m3, 1'b0} + 52'(ONE_Q30 >> 1)) >> 30);
	assign ok_m3   = sb_m3.status == ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q      <= ok_m3 ? x_m3 : '0;
			y_q      <= ok_m3 ? y_round : '0;
			arc_q    <= ok_m3 ? sb_m3.arc : '0;
			status_q <= sb_m3.status;
		end
	end

	assign out_valid       = out_valid_q;
	assign x_offset_mm     = x_q;
	assign y_offset_mm     = y_q;
	assign arc_distance_mm = arc_q;
	assign status          = status_q;

	// a flagged result never carries offsets
	`CCPO_ASSERT_NOW(a_err_fields_zero, out_valid_q && (status_q != ST_OK), (x_q == '0) && (y_q == '0) && (arc_q == '0), "error result with nonzero fields")
	// the sine is clamped at zero, so the tangent distance is never negative
	`CCPO_ASSERT_NOW(a_x_nonneg, out_valid_q, !x_q[OFS_W-1], "negative tangent distance")
	// a stall freezes the valid bits inside the pipeline
	`CCPO_ASSERT_NEXT(a_stall_hold, !adv, $stable(v_s1) && $stable(v_s3) && $stable(v_m3), "pipeline moved during stall")

endmodule

`default_nettype wire

// File: verif/tb_circular_curve_point_offsets.sv
`timescale 1ns / 100ps

module tb_circular_curve_point_offsets;
	import ccpo_pkg::*;

	localparam int LATENCY   = 38 + CORDIC_STAGES_DEF;
	localparam int N_RANDOM  = 1500;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint PI_Q = 64'd1686629713;

	// expected result of one point
	typedef struct {
		logic signed [OFS_W-1:0] x_ofs;
		logic [OFS_W-1:0]        y_ofs;
		logic [LEN_W-1:0]        arc;
		logic [ST_W-1:0]         st;
	} offsets_t;

	// pending stake-out results, oldest first
	class offset_scoreboard;
		offsets_t pending[$];
		int       n_errors;
		int       n_checked;
		logic [LEN_W-1:0] radius;
		logic [LEN_W-1:0] arc_len;
		logic [NPT_W-1:0] n_pts;

		function new();
			radius = RADIUS_RST;
			arc_len = ARC_RST;
			n_pts = POINTS_RST;
			n_errors = 0;
			n_checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
			if (idx == REG_RADIUS) radius = val;
			else if (idx == REG_ARC) arc_len = val;
			else if (idx == REG_POINTS) n_pts = val[NPT_W-1:0];
		endfunction

		function longint atan_q29(int i);
			longint t[10];
			t = '{421657428, 248918915, 131521918, 66762579, 33510843,
				16771758, 8387925, 4194219, 2097141, 1048575};
			if (i < 10) return t[i];
			if (i >= 30) return 0;
			return longint'(64'd1 << (29 - i));
		endfunction

		// arithmetic shift of a signed value floors, as the block does
		function longint sine_q30(longint z_in);
			longint x, y, z, dx, dy;
			x = 652032874;
			y = 0;
			z = z_in;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_q29(i);
				end else begin
					x += dx; y -= dy; z += atan_q29(i);
				end
			end
			if (y < 0) y = 0;
			if (y > 64'sd1073741824) y = 64'sd1073741824;
			return y;
		endfunction

		function void note_point(logic [IDX_W-1:0] k);
			offsets_t e;
			longint unsigned segs, num, den, ang, xo, yo, sq, arcv;
			longint a, af, s, h;
			e = '{x_ofs: '0, y_ofs: '0, arc: '0, st: ST_OK};
			segs = longint'(n_pts > MAX_POINTS_DEF ? MAX_POINTS_DEF : n_pts) + 1;
			if (k > segs) begin
				e.st = ST_INDEX;
			end else if (radius == 0) begin
				e.st = ST_RADIUS;
			end else begin
				num = (longint'(k) * longint'(arc_len)) << 29;
				den = segs * longint'(radius);
				ang = (num + den / 2) / den;
				if (ang > PI_Q) begin
					e.st = ST_ANGLE;
				end else begin
					a = ang;
					af = (a > PI_Q - a) ? PI_Q - a : a;
					s = sine_q30(af);
					h = sine_q30(a / 2);
					xo = (longint'(radius) * s + 64'd536870912) >> 30;
					sq = (h * h + 64'd536870912) >> 30;
					yo = (2 * longint'(radius) * sq + 64'd536870912) >> 30;
					arcv = (longint'(k) * longint'(arc_len) + segs / 2) / segs;
					e.x_ofs = xo[OFS_W-1:0];
					e.y_ofs = yo[OFS_W-1:0];
					e.arc = arcv[LEN_W-1:0];
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(offsets_t got);
			offsets_t e;
			n_checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d arc=%0d st=%0d", $time,
					got.x_ofs, got.y_ofs, got.arc, got.st);
				n_errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x_ofs !== e.x_ofs) begin
				$display("%0t: x_offset_mm expected %0d actual %0d", $time, e.x_ofs, got.x_ofs);
				n_errors++;
			end
			if (got.y_ofs !== e.y_ofs) begin
				$display("%0t: y_offset_mm expected %0d actual %0d", $time, e.y_ofs, got.y_ofs);
				n_errors++;
			end
			if (got.arc !== e.arc) begin
				$display("%0t: arc_distance_mm expected %0d actual %0d", $time, e.arc, got.arc);
				n_errors++;
			end
			if (got.st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
				n_errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IDX_W-1:0] point_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OFS_W-1:0] x_offset_mm;
	logic [OFS_W-1:0] y_offset_mm;
	logic [LEN_W-1:0] arc_distance_mm;
	logic [ST_W-1:0] status;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [LEN_W-1:0] cfg_data = '0;

	offset_scoreboard sb;
	longint cycles = 0;
	int n_sent = 0;
	int n_settings = 0;
	// long receiver hold-off, requested by the stimulus process
	bit hold_req = 1'b0;

	circular_curve_point_offsets u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .point_index(point_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_offset_mm(x_offset_mm), .y_offset_mm(y_offset_mm),
		.arc_distance_mm(arc_distance_mm), .status(status),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output monitor: a transfer is sampled at the edge, before nba updates
	always @(posedge clk) begin
		offsets_t got;
		if (arst_n && out_valid && out_ready) begin
			got.x_ofs = x_offset_mm;
			got.y_ofs = y_offset_mm;
			got.arc = arc_distance_mm;
			got.st = status;
			sb.check_result(got);
		end
	end

	// receiver: random gaps, plus one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one input transfer; valid stays up across back-to-back items
	task automatic send_point(logic [IDX_W-1:0] k, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_index <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_point(k);
		n_sent++;
	endtask

	// drop valid, wait for the pipeline to empty, then let it settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic setup(logic [LEN_W-1:0] r, logic [LEN_W-1:0] l, logic [NPT_W-1:0] n);
		write_reg(REG_RADIUS, r);
		write_reg(REG_ARC, l);
		write_reg(REG_POINTS, n);
		// unused index is ignored by the block
		write_reg(2'd3, LEN_W'($urandom));
		@(posedge clk);
		n_settings++;
	endtask

	// index drawn mostly within range, sometimes past the end point
	function automatic logic [IDX_W-1:0] pick_index();
		int segs;
		segs = sb.n_pts + 1;
		case ($urandom_range(0, 9))
			0: return IDX_W'($urandom);
			1: return IDX_W'(segs);
			2: return '0;
			default: return IDX_W'($urandom_range(0, segs));
		endcase
	endfunction

	initial begin
		logic [LEN_W-1:0] r, l;
		logic [NPT_W-1:0] n;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, endpoints and index too large
		send_point(0, 0);
		send_point(1, 0);
		send_point(4, 1);
		send_point(5, 1);
		send_point(6, 0);
		send_point(11'h7FF, 0);
		drain();
		// zero radius, with good and bad index
		setup(0, 1000, 4);
		send_point(2, 0);
		send_point(6, 0);
		drain();
		// angle beyond pi and right at a half turn
		setup(1000, 20'hFFFFF, 0);
		send_point(1, 0);
		send_point(0, 1);
		drain();
		setup(1000, 3142, 0);
		send_point(1, 0);
		drain();
		setup(1000, 3141, 1);
		send_point(2, 0);
		send_point(1, 0);
		drain();
		// extreme radius and point counts
		setup(20'hFFFFF, 20'hFFFFF, 10'h3FF);
		send_point(0, 0);
		send_point(512, 0);
		send_point(1024, 0);
		send_point(1025, 0);
		send_point(11'h7FF, 0);
		drain();
		setup(1, 1, 10'h3FF);
		send_point(1024, 0);
		send_point(1, 0);
		drain();

		// random phases with a new setting each
		for (int ph = 0; ph < 15; ph++) begin
			case (ph % 4)
				0: r = LEN_W'($urandom_range(1, 20'hFFFFF));
				1: r = LEN_W'($urandom_range(1, 2000));
				2: r = (ph == 6) ? '0 : 20'hFFFFF;
				default: r = LEN_W'($urandom);
			endcase
			l = (ph % 3 == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, r * 3));
			n = (ph % 5 == 0) ? 10'h3FF : NPT_W'($urandom_range(0, 40));
			setup(r, l, n);
			for (int i = 0; i < N_RANDOM / 15; i++) begin
				// once the receiver stops for a long stretch while we keep sending
				if (ph == 3 && i == 10) hold_req = 1'b1;
				send_point(pick_index(), ($urandom_range(0, 4) == 0) || ph == 3);
			end
			drain();
		end

		$display("sent %0d points over %0d register settings, %0d results checked",
			n_sent, n_settings, sb.n_checked);
		if (sb.n_errors == 0 && sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
